// ===== rtl/tcofq_pkg.sv =====
// shared types and codes for the two-class oldest-first queue
package tcofq_pkg;

  localparam logic OP_ENQ = 1'b0;
  localparam logic OP_DEQ = 1'b1;

  localparam logic [1:0] WANT_ANY = 2'd0;
  localparam logic [1:0] WANT_A   = 2'd1;
  localparam logic [1:0] WANT_B   = 2'd2;

  localparam logic [1:0] STAT_ENQ  = 2'd0;
  localparam logic [1:0] STAT_RET  = 2'd1;
  localparam logic [1:0] STAT_FULL = 2'd2;
  localparam logic [1:0] STAT_NONE = 2'd3;

  // one stored entry: arrival stamp above, value below
  typedef struct packed {
    logic        [31:0] stamp;
    logic signed [31:0] value;
  } entry_t;

  typedef struct packed {
    logic push;
    logic pop;
  } fifo_ctrl_t;

  typedef struct packed {
    logic empty;
    logic full;
  } fifo_stat_t;

endpackage

// ===== rtl/tcofq_fifo.sv =====
// one class fifo: entry memory with registered head read, pointers and fill count
module tcofq_fifo import tcofq_pkg::*; #(
  parameter int DEPTH = 256
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       rd_en,
  input  fifo_ctrl_t ctrl,
  input  entry_t     wr_entry,
  output entry_t     rd_entry,
  output fifo_stat_t stat
);

  localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  entry_t mem [DEPTH];
  entry_t rd_data_r;

  logic [IDX_W-1:0] head_r, head_nxt;
  logic [IDX_W-1:0] tail_r, tail_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;

  // memory write at tail, head read registered
  always_ff @(posedge clk) begin
    if (ctrl.push) begin
      mem[tail_r] <= wr_entry;
    end
    if (rd_en) begin
      rd_data_r <= mem[head_r];
    end
  end

  assign rd_entry   = rd_data_r;
  assign stat.empty = (count_r == '0);
  assign stat.full  = (count_r == CNT_W'(DEPTH));

  always_comb begin
    head_nxt  = head_r;
    tail_nxt  = tail_r;
    count_nxt = count_r;
    if (ctrl.push) begin
      tail_nxt  = (tail_r == IDX_W'(DEPTH - 1)) ? '0 : tail_r + 1'b1;
      count_nxt = count_r + 1'b1;
    end
    if (ctrl.pop) begin
      head_nxt  = (head_r == IDX_W'(DEPTH - 1)) ? '0 : head_r + 1'b1;
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r  <= '0;
      tail_r  <= '0;
      count_r <= '0;
    end else begin
      head_r  <= head_nxt;
      tail_r  <= tail_nxt;
      count_r <= count_nxt;
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(DEPTH))
    else $error("fill count above depth");

  a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
    ctrl.push |-> !stat.full)
    else $error("push into full fifo");

  a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
    ctrl.pop |-> !stat.empty)
    else $error("pop from empty fifo");

endmodule

// ===== rtl/two_class_oldest_first_queue_unit.sv =====
// top level of the two-class oldest-first queue unit
//
// usage
//   command channel: an item is taken at a rising edge with start high and
//   busy low; in_op selects enqueue (in_value) or dequeue (in_want_class:
//   any, class a only, class b only)
//   result channel: every item gives exactly one result, shown on out_status
//   and out_value for one cycle with out_strobe high; the receiver cannot
//   stall, so nothing is held back
// timing
//   the acceptance edge launches the head reads of both entry memories;
//   the following cycle (busy high) decides, pushes or pops and registers
//   the result, which appears in the cycle after that
//   an item passes through the synchronous memory read of the heads and then
//   the read-modify-write; a new item may be taken while the
//   previous result is on the output ports
// reset
//   synchronous, active low: both fifos empty, arrival counter zero, no
//   result pending; the entry memories are not cleared, the fill counts
//   guard every read
module two_class_oldest_first_queue_unit import tcofq_pkg::*; #(
  parameter int QUEUE_DEPTH = 256
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  logic               in_op,
  input  logic signed [31:0] in_value,
  input  logic        [1:0]  in_want_class,
  output logic               out_strobe,
  output logic        [1:0]  out_status,
  output logic signed [31:0] out_value
);

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_EXEC = 1'b1;

  logic state_r, state_nxt;

  // captured command
  logic               op_r;
  logic signed [31:0] value_r;
  logic        [1:0]  want_r;

  logic [31:0] arrival_r, arrival_nxt;

  // registered result
  logic               out_strobe_r, out_strobe_nxt;
  logic        [1:0]  out_status_r, out_status_nxt;
  logic signed [31:0] out_value_r, out_value_nxt;

  logic accept;

  fifo_ctrl_t ctrl_a, ctrl_b;
  fifo_stat_t stat_a, stat_b;
  entry_t     head_a, head_b;
  entry_t     new_entry;

  logic        is_class_a;
  logic [31:0] stamp_diff;
  logic        a_older;

  assign busy   = (state_r == ST_EXEC);
  assign accept = start && !busy;

  assign out_strobe = out_strobe_r;
  assign out_status = out_status_r;
  assign out_value  = out_value_r;

  tcofq_fifo #(.DEPTH(QUEUE_DEPTH)) u_fifo_a (
    .clk      (clk),
    .rst_n    (rst_n),
    .rd_en    (accept),
    .ctrl     (ctrl_a),
    .wr_entry (new_entry),
    .rd_entry (head_a),
    .stat     (stat_a)
  );

  tcofq_fifo #(.DEPTH(QUEUE_DEPTH)) u_fifo_b (
    .clk      (clk),
    .rst_n    (rst_n),
    .rd_en    (accept),
    .ctrl     (ctrl_b),
    .wr_entry (new_entry),
    .rd_entry (head_b),
    .stat     (stat_b)
  );

  // class a takes strictly positive values
  assign is_class_a      = (value_r > 32'sd0);
  assign new_entry.stamp = arrival_r;
  assign new_entry.value = value_r;

  // age compare modulo 2^32: a is older when the difference is negative
  assign stamp_diff = head_a.stamp - head_b.stamp;
  assign a_older    = stamp_diff[31];

  // decision, push or pop, result
  always_comb begin
    ctrl_a         = '0;
    ctrl_b         = '0;
    arrival_nxt    = arrival_r;
    out_strobe_nxt = 1'b0;
    out_status_nxt = out_status_r;
    out_value_nxt  = out_value_r;
    if (state_r == ST_EXEC) begin
      out_strobe_nxt = 1'b1;
      out_value_nxt  = '0;
      out_status_nxt = STAT_NONE;
      if (op_r == OP_ENQ) begin
        if (is_class_a ? stat_a.full : stat_b.full) begin
          out_status_nxt = STAT_FULL;
        end else begin
          ctrl_a.push    = is_class_a;
          ctrl_b.push    = !is_class_a;
          arrival_nxt    = arrival_r + 32'd1;
          out_status_nxt = STAT_ENQ;
        end
      end else begin
        case (want_r)
          WANT_ANY: begin
            if (!stat_a.empty && !stat_b.empty) begin
              ctrl_a.pop = a_older;
              ctrl_b.pop = !a_older;
            end else begin
              ctrl_a.pop = !stat_a.empty;
              ctrl_b.pop = stat_a.empty && !stat_b.empty;
            end
          end
          WANT_A:  ctrl_a.pop = !stat_a.empty;
          WANT_B:  ctrl_b.pop = !stat_b.empty;
          default: begin
            ctrl_a.pop = 1'b0;
            ctrl_b.pop = 1'b0;
          end
        endcase
        if (ctrl_a.pop) begin
          out_status_nxt = STAT_RET;
          out_value_nxt  = head_a.value;
        end else if (ctrl_b.pop) begin
          out_status_nxt = STAT_RET;
          out_value_nxt  = head_b.value;
        end
      end
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: if (accept) state_nxt = ST_EXEC;
      ST_EXEC: state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  // command capture and result status and value registers, no reset needed
  always_ff @(posedge clk) begin
    if (accept) begin
      op_r    <= in_op;
      value_r <= in_value;
      want_r  <= in_want_class;
    end
    out_status_r <= out_status_nxt;
    out_value_r  <= out_value_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      arrival_r    <= '0;
      out_strobe_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      arrival_r    <= arrival_nxt;
      out_strobe_r <= out_strobe_nxt;
    end
  end

  // a result follows only the decision cycle
  a_strobe_after_exec: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe_r |-> $past(state_r == ST_EXEC))
    else $error("result strobe without a decision cycle");

  // the decision state is always followed by idle in the next cycle
  a_exec_one_cycle: assert property (@(posedge clk) disable iff (!rst_n)
    busy |=> !busy)
    else $error("busy held longer than one cycle");

  // at most one fifo changes per item
  a_single_access: assert property (@(posedge clk) disable iff (!rst_n)
    $countones({ctrl_a.push, ctrl_a.pop, ctrl_b.push, ctrl_b.pop}) <= 1)
    else $error("more than one fifo access in one item");

endmodule

// ===== verif/tb.sv =====
// testbench for the two-class oldest-first queue unit: mirrored fifos, directed and random commands
module tb;
  import tcofq_pkg::*;

  localparam int DEPTH = 256;
  // the whole run is under two thousand items, so this is ample
  localparam int CYCLE_LIMIT = 400000;
  // selector code that the package leaves unnamed: asks for nothing
  localparam logic [1:0] WANT_UNUSED = 2'd3;

  // what one result should carry
  typedef struct packed {
    logic        [1:0]  status;
    logic signed [31:0] value;
  } outcome_t;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               start = 1'b0;
  logic               busy;
  logic               in_op = OP_ENQ;
  logic signed [31:0] in_value = '0;
  logic        [1:0]  in_want_class = WANT_ANY;
  logic               out_strobe;
  logic        [1:0]  out_status;
  logic signed [31:0] out_value;

  // mirror of the block: one queue per class, plus the arrival stamp
  entry_t      mirror_a[$];
  entry_t      mirror_b[$];
  logic [31:0] mirror_stamp = '0;
  // results still to come, oldest first
  outcome_t    outcomes_due[$];

  int errors = 0;
  int cycle_count = 0;
  // chance in a hundred that the sender pauses after an item
  int idle_pct = 0;

  two_class_oldest_first_queue_unit #(
    .QUEUE_DEPTH(DEPTH)
  ) DUT (
    .clk          (clk),
    .rst_n        (rst_n),
    .start        (start),
    .busy         (busy),
    .in_op        (in_op),
    .in_value     (in_value),
    .in_want_class(in_want_class),
    .out_strobe   (out_strobe),
    .out_status   (out_status),
    .out_value    (out_value)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // hard stop in case a handshake never completes
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  task automatic report_mismatch(input string what);
    errors++;
    $display("cycle %0d: %s", cycle_count, what);
  endtask

  // applies one command to the mirror and gives the result it must produce
  function automatic outcome_t apply_command(input logic op, input logic signed [31:0] val,
                                             input logic [1:0] want);
    outcome_t    res;
    entry_t      fresh;
    entry_t      taken;
    logic [31:0] age_gap;
    logic        take_a;
    logic        take_b;
    res.status = STAT_NONE;
    res.value = '0;
    take_a = 1'b0;
    take_b = 1'b0;
    if (op == OP_ENQ) begin
      fresh.stamp = mirror_stamp;
      fresh.value = val;
      // class a is strictly positive, zero and negatives go to class b
      if (val > 0) begin
        if (mirror_a.size() >= DEPTH) begin
          res.status = STAT_FULL;
        end else begin
          mirror_a.push_back(fresh);
          res.status = STAT_ENQ;
        end
      end else begin
        if (mirror_b.size() >= DEPTH) begin
          res.status = STAT_FULL;
        end else begin
          mirror_b.push_back(fresh);
          res.status = STAT_ENQ;
        end
      end
      // a rejected push leaves the stamp where it was
      if (res.status == STAT_ENQ) mirror_stamp = mirror_stamp + 32'd1;
    end else begin
      case (want)
        WANT_ANY: begin
          if (mirror_a.size() != 0 && mirror_b.size() != 0) begin
            // wrap-safe age test: a is older when the difference is negative
            age_gap = mirror_a[0].stamp - mirror_b[0].stamp;
            take_a = age_gap[31];
            take_b = !age_gap[31];
          end else begin
            take_a = (mirror_a.size() != 0);
            take_b = (mirror_b.size() != 0);
          end
        end
        WANT_A: take_a = (mirror_a.size() != 0);
        WANT_B: take_b = (mirror_b.size() != 0);
        default: ;
      endcase
      if (take_a) begin
        taken = mirror_a.pop_front();
        res.status = STAT_RET;
        res.value = taken.value;
      end else if (take_b) begin
        taken = mirror_b.pop_front();
        res.status = STAT_RET;
        res.value = taken.value;
      end
    end
    return res;
  endfunction

  // drives one command, waits for it to be taken and books its result
  task automatic send_command(input logic op, input logic signed [31:0] val,
                              input logic [1:0] want);
    start <= 1'b1;
    in_op <= op;
    in_value <= val;
    in_want_class <= want;
    @(posedge clk);
    while (busy !== 1'b0) @(posedge clk);
    outcomes_due.push_back(apply_command(op, val, want));
    // otherwise start stays high and the next command follows straight on
    if ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      repeat ($urandom_range(4, 1)) @(posedge clk);
    end
  endtask

  // a value of the chosen class, leaning on the edges of each range
  function automatic logic signed [31:0] pick_entry_value(input int a_pct);
    logic signed [31:0] v;
    int                 kind;
    kind = $urandom_range(9);
    if ($urandom_range(99) < a_pct) begin
      case (kind)
        0:       v = 32'sd1;
        1:       v = 32'sh7fffffff;
        2, 3:    v = $urandom_range(255, 1);
        default: v = $urandom & 32'h7fffffff;
      endcase
      if (v == 0) v = 32'sd1;
    end else begin
      case (kind)
        0:       v = 32'sd0;
        1:       v = -32'sd1;
        2:       v = 32'sh80000000;
        3:       v = -$urandom_range(255, 0);
        default: v = $urandom | 32'h80000000;
      endcase
    end
    return v;
  endfunction

  // every result is checked against the oldest booked expectation
  always @(posedge clk) begin : check_results
    outcome_t due;
    if (rst_n === 1'b1) begin
      if (out_strobe === 1'b1) begin
        if (outcomes_due.size() == 0) begin
          report_mismatch($sformatf("result with none expected: status %0d value %0d",
                                    out_status, out_value));
        end else begin
          due = outcomes_due.pop_front();
          if (out_status !== due.status)
            report_mismatch($sformatf("status %0d, expected %0d", out_status, due.status));
          if (out_value !== due.value)
            report_mismatch($sformatf("value %0d, expected %0d", out_value, due.value));
        end
      end else if (out_strobe !== 1'b0) begin
        report_mismatch("result strobe unknown");
      end
    end
  end

  // every selector on empty fifos, the unused selector, ignored fields
  task automatic test_empty_requests;
    send_command(OP_DEQ, 32'sh7fffffff, WANT_ANY);
    send_command(OP_DEQ, 32'sh80000000, WANT_A);
    send_command(OP_DEQ, -32'sd1, WANT_B);
    send_command(OP_DEQ, 32'sd0, WANT_UNUSED);
    // enqueue ignores the selector
    send_command(OP_ENQ, 32'sd0, WANT_UNUSED);
    // unused selector with an entry waiting still returns nothing
    send_command(OP_DEQ, 32'sd0, WANT_UNUSED);
    // class a empty while class b holds an entry
    send_command(OP_DEQ, 32'sd0, WANT_A);
    send_command(OP_DEQ, 32'sd0, WANT_B);
  endtask

  // class boundaries at the extremes of the value range, drained by age
  task automatic test_value_extremes;
    send_command(OP_ENQ, 32'sh7fffffff, WANT_A);
    send_command(OP_ENQ, 32'sh80000000, WANT_B);
    send_command(OP_ENQ, 32'sd1, WANT_ANY);
    send_command(OP_ENQ, -32'sd1, WANT_UNUSED);
    send_command(OP_ENQ, 32'sd0, WANT_A);
    repeat (6) send_command(OP_DEQ, $urandom, WANT_ANY);
  endtask

  // class-only requests pull entries out of age order
  task automatic test_class_select;
    send_command(OP_ENQ, -32'sd5, WANT_ANY);
    send_command(OP_ENQ, 32'sd7, WANT_ANY);
    send_command(OP_ENQ, -32'sd9, WANT_ANY);
    send_command(OP_DEQ, 32'sd0, WANT_A);
    send_command(OP_DEQ, 32'sd0, WANT_ANY);
    send_command(OP_DEQ, 32'sd0, WANT_B);
  endtask

  // both fifos to full, one push rejected each, then a full drain by age
  task automatic test_fill_to_full;
    for (int i = 0; i < DEPTH; i++) send_command(OP_ENQ, pick_entry_value(100), WANT_ANY);
    send_command(OP_ENQ, 32'sh7fffffff, WANT_ANY);
    for (int i = 0; i < DEPTH; i++) send_command(OP_ENQ, pick_entry_value(0), WANT_ANY);
    send_command(OP_ENQ, 32'sd0, WANT_ANY);
    // make room in class a, then refill it with the youngest entry
    send_command(OP_DEQ, 32'sd0, WANT_A);
    send_command(OP_ENQ, 32'sd5, WANT_B);
    for (int i = 0; i < 2 * DEPTH + 1; i++) send_command(OP_DEQ, $urandom, WANT_ANY);
  endtask

  // bursts that lean towards pushing or popping and towards one class
  task automatic test_random_traffic(input int count, input int pct);
    int                 sent;
    int                 run;
    int                 enq_pct;
    int                 a_pct;
    int                 roll;
    logic [1:0]         want;
    logic signed [31:0] val;
    sent = 0;
    idle_pct = pct;
    while (sent < count) begin
      run = $urandom_range(150, 20);
      enq_pct = 15 + 35 * $urandom_range(2);
      a_pct = 15 + 35 * $urandom_range(2);
      for (int i = 0; i < run && sent < count; i++) begin
        roll = $urandom_range(99);
        want = (roll < 45) ? WANT_ANY : (roll < 70) ? WANT_A :
               (roll < 95) ? WANT_B : WANT_UNUSED;
        if ($urandom_range(99) < enq_pct) begin
          val = ($urandom_range(9) == 0) ? $urandom : pick_entry_value(a_pct);
          send_command(OP_ENQ, val, 2'($urandom_range(3)));
        end else begin
          send_command(OP_DEQ, $urandom, want);
        end
        sent++;
      end
    end
  endtask

  initial begin
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    idle_pct = 26;
    test_empty_requests();
    test_value_extremes();
    test_class_select();
    idle_pct = 0;
    test_fill_to_full();
    // sender pauses sometimes, then often, then never
    test_random_traffic(250, 26);
    test_random_traffic(250, 68);
    test_random_traffic(250, 0);
    start <= 1'b0;
    while (outcomes_due.size() != 0) @(posedge clk);
    // room for a stray result after the last one
    repeat (4) @(posedge clk);
    if (errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

// ===== files.f =====
rtl/tcofq_pkg.sv
rtl/tcofq_fifo.sv
rtl/two_class_oldest_first_queue_unit.sv
verif/tb.sv
